// File: rtl/i2c_master_byte_engine_defines.svh
// ---------------------------------------------------------------------------
// i2c_master_byte_engine_defines
// Assertion macros used by the checker file of the I2C master byte engine.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// check on every clock edge outside reset
`define I2CM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("i2c master check failed");

// check on every clock edge, reset included
`define I2CM_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2c master reset check failed");

`endif

// File: rtl/i2cm_pkg.sv
// ---------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and bus programs of the I2C master byte engine.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 2'd1;

  localparam logic [15:0] PAUSE_RESET   = 16'd80;
  localparam logic [7:0]  STRETCH_RESET = 8'd255;
  localparam logic [2:0]  BIT_LAST      = 3'd7;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] PROG_START = 2'd0;
  localparam logic [1:0] PROG_STOP  = 2'd1;
  localparam logic [1:0] PROG_WRITE = 2'd2;
  localparam logic [1:0] PROG_READ  = 2'd3;

  typedef enum logic [3:0] {
    OP_SDA_LOW   = 4'd0,
    OP_SDA_REL   = 4'd1,
    OP_SCL_LOW   = 4'd2,
    OP_SCL_REL   = 4'd3,
    OP_PAUSE     = 4'd4,
    OP_WAIT      = 4'd5,
    OP_SDA_BIT   = 4'd6,
    OP_CLK_SHIFT = 4'd7,
    OP_GET_ACK   = 4'd8,
    OP_GET_BIT   = 4'd9,
    OP_SDA_ACK   = 4'd10
  } op_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       rd_ack;
    logic       sda_in;
    logic       scl_in;
  } item_t;

  typedef struct packed {
    logic       sda_drive_low;
    logic       scl_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] rx_byte;
  } result_t;

  function automatic logic [3:0] prog_len(input logic [1:0] prog);
    logic [3:0] len;
    case (prog)
      PROG_START: len = 4'd7;
      PROG_STOP:  len = 4'd7;
      PROG_WRITE: len = 4'd13;
      default:    len = 4'd14;
    endcase
    return len;
  endfunction

  function automatic logic prog_loops(input logic [1:0] prog, input logic [3:0] step);
    return ((prog == PROG_WRITE) || (prog == PROG_READ)) && (step == 4'd5);
  endfunction

  function automatic logic [3:0] prog_loop_to(input logic [1:0] prog);
    return (prog == PROG_READ) ? 4'd1 : 4'd0;
  endfunction

  function automatic op_t prog_op(input logic [1:0] prog, input logic [3:0] step);
    op_t op;
    op = OP_PAUSE;
    case (prog)
      PROG_START: begin
        case (step)
          4'd0:    op = OP_SDA_REL;
          4'd1:    op = OP_SCL_REL;
          4'd2:    op = OP_WAIT;
          4'd4:    op = OP_SDA_LOW;
          4'd6:    op = OP_SCL_LOW;
          default: op = OP_PAUSE;
        endcase
      end
      PROG_STOP: begin
        case (step)
          4'd0:    op = OP_SDA_LOW;
          4'd2:    op = OP_SCL_REL;
          4'd3:    op = OP_WAIT;
          4'd5:    op = OP_SDA_REL;
          default: op = OP_PAUSE;
        endcase
      end
      PROG_WRITE: begin
        case (step)
          4'd0:    op = OP_SDA_BIT;
          4'd2:    op = OP_SCL_REL;
          4'd3:    op = OP_WAIT;
          4'd5:    op = OP_CLK_SHIFT;
          4'd6:    op = OP_SDA_REL;
          4'd8:    op = OP_SCL_REL;
          4'd9:    op = OP_WAIT;
          4'd11:   op = OP_GET_ACK;
          default: op = OP_PAUSE;
        endcase
      end
      default: begin
        case (step)
          4'd0:    op = OP_SDA_REL;
          4'd2:    op = OP_SCL_REL;
          4'd3:    op = OP_WAIT;
          4'd5:    op = OP_GET_BIT;
          4'd6:    op = OP_SDA_ACK;
          4'd8:    op = OP_SCL_REL;
          4'd9:    op = OP_WAIT;
          4'd11:   op = OP_SCL_LOW;
          4'd12:   op = OP_SDA_REL;
          default: op = OP_PAUSE;
        endcase
      end
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// File: rtl/i2c_master_byte_engine.sv
// ---------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master; each input beat is one tick of the bus sequencer.
// ---------------------------------------------------------------------------
//   channel  handshake              payload
//   in       in_valid / in_stall    cmd tx_byte rd_ack sda_in scl_in
//   out      out_valid / out_stall  sda_drive_low scl_drive_low busy_res
//                                   done_res ack_seen rx_byte
//   cfg      cfg_valid / cfg_ready  cfg_index cfg_data
//
// One input beat per cycle while in_stall is low; a result beat passes the input
// register, then the result register after one tick of sequencing.
// Every input beat yields exactly one result beat.
// Reset clears the sequencer, loads config defaults and empties both registers.
// out_stall holds the result register and, once the input register is full,
// raises in_stall in the same cycle. cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [2:0]                       cmd,
  input  wire logic [7:0]                       tx_byte,
  input  wire logic                             rd_ack,
  input  wire logic                             sda_in,
  input  wire logic                             scl_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  sda_drive_low,
  output logic                                  scl_drive_low,
  output logic                                  busy_res,
  output logic                                  done_res,
  output logic                                  ack_seen,
  output logic [7:0]                            rx_byte,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cm_pkg::*;

  logic    in_q_valid;
  item_t   in_q;
  logic    out_hold;
  logic    step_en;
  result_t res;
  result_t out_q;

  assign out_hold  = out_valid && out_stall;
  assign in_stall  = in_q_valid && out_hold;
  assign step_en   = in_q_valid && !out_hold;
  assign cfg_ready = 1'b1;

  i2cm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (step_en),
    .item      (in_q),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (step_en) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (!in_stall) begin
      in_q <= '{cmd: cmd, tx_byte: tx_byte, rd_ack: rd_ack,
                sda_in: sda_in, scl_in: scl_in};
    end
    if (step_en) begin
      out_q <= res;
    end
  end

  assign sda_drive_low = out_q.sda_drive_low;
  assign scl_drive_low = out_q.scl_drive_low;
  assign busy_res      = out_q.busy_res;
  assign done_res      = out_q.done_res;
  assign ack_seen      = out_q.ack_seen;
  assign rx_byte       = out_q.rx_byte;

endmodule

`default_nettype wire

// File: rtl/i2cm_seq.sv
// ---------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: config registers, program state and one tick of work.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             step_en,
  input  wire i2cm_pkg::item_t                  item,
  output i2cm_pkg::result_t                     res
);
  import i2cm_pkg::*;

  logic [15:0] pause_ticks;
  logic [7:0]  stretch_limit;

  logic [2:0]  active_op,    active_op_next;
  logic [3:0]  seq_step,     seq_step_next;
  logic [2:0]  bit_index,    bit_index_next;
  logic [7:0]  shift_data,   shift_data_next;
  logic [15:0] pause_left,   pause_left_next;
  logic [7:0]  stretch_left, stretch_left_next;
  logic        sda_pull,     sda_pull_next;
  logic        scl_pull,     scl_pull_next;
  logic        ack_flag,     ack_flag_next;
  logic        ack_request,  ack_request_next;
  logic [7:0]  rx_hold,      rx_hold_next;

  logic        run;
  logic        adv;
  logic        done;
  logic [2:0]  e_op;
  logic [3:0]  e_step;
  logic [2:0]  e_bit;
  logic [7:0]  e_shift;
  logic [1:0]  prog;
  logic [3:0]  nstep;
  logic        load;
  op_t         cur_op;
  op_t         new_op;

  always_comb begin
    run     = 1'b0;
    adv     = 1'b0;
    done    = 1'b0;
    load    = 1'b0;
    nstep   = 4'd0;
    e_op    = active_op;
    e_step  = seq_step;
    e_bit   = bit_index;
    e_shift = shift_data;
    ack_request_next = ack_request;
    if (active_op == CMD_NONE) begin
      if ((item.cmd >= CMD_START) && (item.cmd <= CMD_READ)) begin
        run              = 1'b1;
        e_op             = item.cmd;
        e_step           = 4'd0;
        e_bit            = 3'd0;
        e_shift          = (item.cmd == CMD_WRITE) ? item.tx_byte : 8'd0;
        ack_request_next = item.rd_ack;
      end
    end else begin
      run = 1'b1;
    end

    prog   = 2'(e_op - 3'd1);
    cur_op = prog_op(prog, e_step);

    active_op_next    = e_op;
    seq_step_next     = e_step;
    bit_index_next    = e_bit;
    shift_data_next   = e_shift;
    pause_left_next   = pause_left;
    stretch_left_next = stretch_left;
    sda_pull_next     = sda_pull;
    scl_pull_next     = scl_pull;
    ack_flag_next     = ack_flag;
    rx_hold_next      = rx_hold;

    if (run) begin
      adv = 1'b1;
      case (cur_op)
        OP_SDA_LOW: sda_pull_next = 1'b1;
        OP_SDA_REL: sda_pull_next = 1'b0;
        OP_SCL_LOW: scl_pull_next = 1'b1;
        OP_SCL_REL: scl_pull_next = 1'b0;
        OP_PAUSE: begin
          if (pause_left > 16'd1) begin
            pause_left_next = pause_left - 16'd1;
            adv             = 1'b0;
          end else begin
            pause_left_next = 16'd0;
          end
        end
        OP_WAIT: begin
          if (!item.scl_in && (stretch_left != 8'd0)) begin
            stretch_left_next = stretch_left - 8'd1;
            adv               = 1'b0;
          end
        end
        OP_SDA_BIT: sda_pull_next = ~e_shift[7];
        OP_CLK_SHIFT: begin
          scl_pull_next   = 1'b1;
          shift_data_next = {e_shift[6:0], 1'b0};
        end
        OP_GET_ACK: begin
          ack_flag_next = ~item.sda_in;
          scl_pull_next = 1'b1;
        end
        OP_GET_BIT: begin
          shift_data_next = {e_shift[6:0], item.sda_in};
          scl_pull_next   = 1'b1;
        end
        default: sda_pull_next = ack_request_next;
      endcase

      if (adv) begin
        if (prog_loops(prog, e_step) && (e_bit < BIT_LAST)) begin
          bit_index_next = e_bit + 3'd1;
          nstep          = prog_loop_to(prog);
          load           = 1'b1;
        end else if ((e_step + 4'd1) >= prog_len(prog)) begin
          if (e_op == CMD_READ) begin
            rx_hold_next = shift_data_next;
          end
          active_op_next = CMD_NONE;
          seq_step_next  = 4'd0;
          done           = 1'b1;
        end else begin
          nstep = e_step + 4'd1;
          load  = 1'b1;
        end
      end
    end

    new_op = prog_op(prog, nstep);
    if (load) begin
      seq_step_next = nstep;
      if (new_op == OP_PAUSE) begin
        pause_left_next = pause_ticks;
      end else if (new_op == OP_WAIT) begin
        stretch_left_next = stretch_limit;
      end
    end

    res.sda_drive_low = sda_pull_next;
    res.scl_drive_low = scl_pull_next;
    res.busy_res      = (active_op_next != CMD_NONE);
    res.done_res      = done;
    res.ack_seen      = ack_flag_next;
    res.rx_byte       = rx_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pause_ticks   <= PAUSE_RESET;
      stretch_limit <= STRETCH_RESET;
      active_op     <= CMD_NONE;
      seq_step      <= 4'd0;
      bit_index     <= 3'd0;
      shift_data    <= 8'd0;
      pause_left    <= 16'd0;
      stretch_left  <= 8'd0;
      sda_pull      <= 1'b0;
      scl_pull      <= 1'b0;
      ack_flag      <= 1'b0;
      ack_request   <= 1'b0;
      rx_hold       <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAUSE_TICKS:   pause_ticks   <= cfg_data;
          CFG_STRETCH_LIMIT: stretch_limit <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (step_en) begin
        active_op    <= active_op_next;
        seq_step     <= seq_step_next;
        bit_index    <= bit_index_next;
        shift_data   <= shift_data_next;
        pause_left   <= pause_left_next;
        stretch_left <= stretch_left_next;
        sda_pull     <= sda_pull_next;
        scl_pull     <= scl_pull_next;
        ack_flag     <= ack_flag_next;
        ack_request  <= ack_request_next;
        rx_hold      <= rx_hold_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2cm_checker.sv
// ---------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master byte engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_byte_engine_defines.svh"

module i2cm_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_stall,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        busy_res,
  input  wire logic        done_res,
  input  wire logic [7:0]  rx_byte
);

  `I2CM_ASSERT(a_done_idle, (out_valid && done_res) |-> !busy_res)
  `I2CM_ASSERT(a_out_hold, (out_valid && out_stall) |=> $stable({out_valid, rx_byte, done_res}))
  `I2CM_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall))
  `I2CM_ASSERT_NR(a_rst_empty, rst |=> !out_valid)

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire
